// File: rtl/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;

   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // per-cycle command broadcast to every digit cell
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // add-3 correction then shift one bit in
      logic shift;   // take the lower neighbor's digit
   } cell_ctrl_type;

endpackage

// File: rtl/sitda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_req_if / sitda_rsp_if
// Valid/ready channels for integer input and character output.
// ----------------------------------------------------------------------------
interface sitda_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sitda_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sitda_pkg::CHAR_W-1:0]  ascii_char;
   logic                          last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// File: rtl/sitda_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_cell
// One BCD digit of the double-dabble chain; also shifts digits out upward.
// ----------------------------------------------------------------------------
module sitda_cell (
   input  logic                            clock,
   input  sitda_pkg::cell_ctrl_type        ctrl,
   input  logic                            carry_in,
   output logic                            carry_out,
   input  logic [sitda_pkg::DIGIT_W-1:0]   lower_digit,
   output logic [sitda_pkg::DIGIT_W-1:0]   digit
);

   logic [sitda_pkg::DIGIT_W-1:0] digit_ff;
   logic [sitda_pkg::DIGIT_W-1:0] digit_in;
   logic [sitda_pkg::DIGIT_W-1:0] adj;

   assign adj       = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[sitda_pkg::DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adj[sitda_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, most significant char first.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | transfer
//  --------+-----+-------------------------+-------------------------
//  req     | in  | value[31:0] signed      | req.valid && req.ready
//  rsp     | out | ascii_char[7:0], last   | rsp.valid && rsp.ready
//
//  Steps: accept, 32 double-dabble shifts through the ten-cell BCD chain, a
//  skip state that drops leading zeros (up to 9) and then leaves, then one
//  character per output transfer, with a minus sign first for a negative value.
//  Reset (synchronous) returns to idle and empties the output register.
//  A stall on rsp holds the character in the output register; the chain
//  waits. A new value is taken as soon as the last character is loaded.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic               clock,
   input  logic               reset,
   sitda_req_if.sink          req,
   sitda_rsp_if.source        rsp
);

   localparam int N  = sitda_pkg::NUM_DIGITS;
   localparam int DW = sitda_pkg::DIGIT_W;

   sitda_pkg::state_type state_ff, state_in;

   // magnitude shifts out msb first into the chain
   logic [sitda_pkg::VALUE_W-1:0]     mag_ff, mag_in;
   logic                              minus_ff, minus_in;
   logic [sitda_pkg::BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   // digits still held in the chain (top cell first)
   logic [sitda_pkg::DIGIT_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sitda_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                              last_ff, last_in;

   sitda_pkg::cell_ctrl_type          ctrl;
   logic [N-1:0]                      carry;
   logic [DW-1:0]                     digits [N];
   logic [DW-1:0]                     top_digit;
   logic                              can_load;

   assign top_digit = digits[N-1];
   assign can_load  = !rsp_valid_ff || rsp.ready;

   assign req.ready      = (state_ff == sitda_pkg::ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ascii_char = char_ff;
   assign rsp.last_char  = last_ff;

   // digit chain: cell 0 is the units digit
   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic          cin;
         logic [DW-1:0] low;
         if (g == 0) begin : g_first
            assign cin = mag_ff[sitda_pkg::VALUE_W-1];
            assign low = '0;
         end else begin : g_rest
            assign cin = carry[g-1];
            assign low = digits[g-1];
         end
         sitda_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .carry_in    (cin),
            .carry_out   (carry[g]),
            .lower_digit (low),
            .digit       (digits[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      minus_in     = minus_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      ctrl         = '0;

      case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (req.valid) begin
               // two's complement magnitude; most negative maps to 2^31
               minus_in   = req.value[sitda_pkg::VALUE_W-1];
               mag_in     = req.value[sitda_pkg::VALUE_W-1] ?
                            (~req.value + 1'b1) : req.value;
               bit_cnt_in = '0;
               ctrl.clear = 1'b1;
               state_in   = sitda_pkg::ST_CONVERT;
            end
         end

         sitda_pkg::ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[sitda_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == sitda_pkg::BIT_CNT_W'(sitda_pkg::VALUE_W - 1)) begin
               dig_cnt_in = sitda_pkg::DIGIT_CNT_W'(N);
               state_in   = sitda_pkg::ST_SKIP;
            end
         end

         sitda_pkg::ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && dig_cnt_ff != sitda_pkg::DIGIT_CNT_W'(1)) begin
               ctrl.shift = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = sitda_pkg::ST_EMIT;
            end
         end

         sitda_pkg::ST_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (minus_ff) begin
                  char_in  = sitda_pkg::MINUS_CHAR;
                  last_in  = 1'b0;
                  minus_in = 1'b0;
               end else begin
                  char_in    = sitda_pkg::DIGIT_BASE + sitda_pkg::CHAR_W'(top_digit);
                  last_in    = (dig_cnt_ff == sitda_pkg::DIGIT_CNT_W'(1));
                  ctrl.shift = 1'b1;
                  dig_cnt_in = dig_cnt_ff - 1'b1;
                  if (dig_cnt_ff == sitda_pkg::DIGIT_CNT_W'(1)) begin
                     state_in = sitda_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      minus_ff   <= minus_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

endmodule

// File: rtl/sitda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module sitda_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sitda_pkg::CHAR_W-1:0]  ascii_char,
   input logic                          last_char
);

   // stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ascii_char) && $stable(last_char))
      else $error("rsp changed while stalled");

   // only minus or a decimal digit leaves the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ascii_char == sitda_pkg::MINUS_CHAR) ||
                    (ascii_char >= sitda_pkg::DIGIT_BASE &&
                     ascii_char <= sitda_pkg::DIGIT_BASE + 8'd9))
      else $error("illegal character");

   // a minus sign is never the end of a run
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ascii_char == sitda_pkg::MINUS_CHAR |-> !last_char)
      else $error("minus flagged as last");

   // one value at a time: intake closes right after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .ascii_char (rsp.ascii_char),
   .last_char  (rsp.last_char)
);

// File: test/sitda_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_text_checker
// Watches the integer and character channels of the signed integer to
// decimal text block, builds the expected characters for every accepted
// value and compares each character transfer in order.
// ----------------------------------------------------------------------------
module sitda_text_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [sitda_pkg::VALUE_W-1:0]        req_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [sitda_pkg::CHAR_W-1:0]         rsp_ascii_char,
   input  logic                                 rsp_last_char,
   output int                                   failure_count,
   output int                                   chars_pending,
   output int                                   values_seen,
   output int                                   negatives_seen,
   output int                                   chars_seen,
   output int                                   longest_text
);

   typedef struct {
      logic [sitda_pkg::VALUE_W-1:0] source_value;
      logic [sitda_pkg::CHAR_W-1:0]  ascii_char;
      logic                          last_char;
   } text_char_type;

   text_char_type decimal_text_q[$];
   int            mismatches = 0;
   int            value_total = 0;
   int            negative_total = 0;
   int            char_total = 0;
   int            longest = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // decimal text of one value: sign first, then digits, no leading zeros
   function automatic void queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] raw);
      logic [sitda_pkg::VALUE_W-1:0] magnitude;
      logic [sitda_pkg::DIGIT_W-1:0] digit_buf [sitda_pkg::NUM_DIGITS];
      int                            ndig;
      int                            text_len;
      magnitude = raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
      ndig = 0;
      do begin
         digit_buf[ndig] = sitda_pkg::DIGIT_W'(magnitude % 10);
         magnitude       = magnitude / 10;
         ndig++;
      end while (magnitude != 0 && ndig < sitda_pkg::NUM_DIGITS);
      if (raw[sitda_pkg::VALUE_W-1]) begin
         decimal_text_q.push_back('{raw, sitda_pkg::MINUS_CHAR, 1'b0});
         negative_total++;
      end
      for (int i = ndig - 1; i >= 0; i--)
         decimal_text_q.push_back('{raw,
                                    sitda_pkg::DIGIT_BASE +
                                    sitda_pkg::CHAR_W'(digit_buf[i]),
                                    i == 0});
      text_len = ndig + int'(raw[sitda_pkg::VALUE_W-1]);
      if (text_len > longest)
         longest = text_len;
      value_total++;
   endfunction

   always @(posedge clock) begin : watch_channels
      text_char_type want;
      if (!reset) begin
         // characters first: a value accepted at this edge cannot emit yet
         if (rsp_valid && rsp_ready) begin
            char_total++;
            if (decimal_text_q.size() == 0) begin
               report_mismatch($sformatf("char 0x%02h last %0b with no value pending",
                                         rsp_ascii_char, rsp_last_char));
            end else begin
               want = decimal_text_q.pop_front();
               if (rsp_ascii_char !== want.ascii_char)
                  report_mismatch($sformatf("value %0d: char 0x%02h, want 0x%02h",
                                            $signed(want.source_value),
                                            rsp_ascii_char, want.ascii_char));
               if (rsp_last_char !== want.last_char)
                  report_mismatch($sformatf("value %0d: last flag %b, want %b",
                                            $signed(want.source_value),
                                            rsp_last_char, want.last_char));
            end
         end
         if (req_valid && req_ready)
            queue_decimal_text(req_value);
      end
      failure_count  <= mismatches;
      chars_pending  <= decimal_text_q.size();
      values_seen    <= value_total;
      negatives_seen <= negative_total;
      chars_seen     <= char_total;
      longest_text   <= longest;
   end

endmodule

// File: test/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed 32-bit values into the decimal text converter: a directed
// set of corner values, then random values spread over every text length,
// with random idle bursts on both channels, one long output hold that backs
// the block up, and a final stretch at full rate. A separate checker
// predicts and compares every character; this module gives the verdict.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

   // no-transfer cycles tolerated; the long hold below is far shorter
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   // conversion plus emit of the longest text, with margin
   localparam int DRAIN_CYCLES   = 60;

   // corner values: zero, single digits, powers of ten and their neighbors,
   // both extremes, alternating bit patterns
   localparam int NUM_CORNERS = 21;
   localparam logic [sitda_pkg::VALUE_W-1:0] CORNER_VALUES [NUM_CORNERS] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
      32'sd99, 32'sd100, -32'sd100,
      32'sh7FFFFFFF, 32'sh80000000, -32'sd2147483647,
      32'sd1000000000, -32'sd1000000000, 32'sd999999999, -32'sd999999999,
      32'sd1234567890, -32'sd1234567890,
      32'h55555555, 32'hAAAAAAAA
   };

   logic clock;
   logic reset;

   sitda_req_if req_ch ();
   sitda_rsp_if rsp_ch ();

   // idling controls, set by the stimulus process; the receiver clears
   // hold_request once the long hold is over
   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_request    = 1'b0;

   int failure_count;
   int chars_pending;
   int values_seen;
   int negatives_seen;
   int chars_seen;
   int longest_text;

   signed_int_to_decimal_ascii DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sitda_text_checker text_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_value      (req_ch.value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_ascii_char (rsp_ch.ascii_char),
      .rsp_last_char  (rsp_ch.last_char),
      .failure_count  (failure_count),
      .chars_pending  (chars_pending),
      .values_seen    (values_seen),
      .negatives_seen (negatives_seen),
      .chars_seen     (chars_seen),
      .longest_text   (longest_text)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // single synchronous reset at start of run
   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Random value with its text length spread evenly over 1..10 digits,
   // plus some raw 32-bit patterns, powers of ten +-1 and both extremes.
   function automatic logic [sitda_pkg::VALUE_W-1:0] pick_random_value();
      longint lo;
      longint hi;
      longint magnitude;
      int     ndig;
      int     kind;
      bit     negative;
      kind     = $urandom_range(0, 7);
      negative = $urandom_range(0, 1);
      if (kind == 0)
         return $urandom();
      if (kind == 1)
         return negative ? 32'h80000000 : 32'h7FFFFFFF;
      if (kind == 2) begin
         magnitude = 1;
         repeat ($urandom_range(0, 9)) magnitude *= 10;
         magnitude = magnitude + longint'({32'd0, $urandom_range(0, 2)}) - 1;
      end else begin
         ndig = $urandom_range(1, 10);
         lo   = 1;
         repeat (ndig - 1) lo *= 10;
         hi   = lo * 10 - 1;
         if (ndig == 1)
            lo = 0;
         // ten-digit range stops at the 32-bit limits
         if (hi > 64'sd2147483647)
            hi = negative ? 64'sd2147483648 : 64'sd2147483647;
         magnitude = lo + longint'({32'd0, $urandom()}) % (hi - lo + 1);
      end
      return negative ? sitda_pkg::VALUE_W'(-magnitude) : sitda_pkg::VALUE_W'(magnitude);
   endfunction

   // Offer one value and hold it until the transfer; valid stays high into
   // the next item unless an idle burst follows.
   task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= $urandom();
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_random_values(input int count);
      repeat (count) send_value(pick_random_value());
   endtask

   // Receiver: random stall bursts when enabled; a hold request makes it
   // refuse every character for the long hold set by LONG_HOLD.
   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0)
            hold_left = LONG_HOLD;
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
            if (hold_left == 0)
               hold_request = 1'b0;
         end else if (!receiver_stalls) begin
            stall_left = 0;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when its quiet count, cleared by any transfer on
   // either channel, reaches WATCHDOG_LIMIT.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no transfer in %0d cycles, %0d chars still due",
               WATCHDOG_LIMIT, chars_pending);
      $display("end of test: mismatches");
      $finish;
   end

   // Stimulus and verdict.
   initial begin : stimulus
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed corners with idling on both sides
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      foreach (CORNER_VALUES[i])
         send_value(CORNER_VALUES[i]);

      // random values, idle bursts on both sides
      send_random_values(120);

      // long output hold while the sender keeps offering back to back:
      // the output register fills and the block must stall its input
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_request    = 1'b1;
      send_random_values(12);

      // stretch with no idling at all
      send_random_values(120);

      // idling again
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      send_random_values(100);

      // last part at full rate
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_random_values(60);
      req_ch.valid <= 1'b0;

      // drain; the pending count is registered, so it lags the last transfer,
      // and a missing character leaves this loop to the watchdog
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d values (%0d negative, corners and all text lengths), %0d chars",
               values_seen, negatives_seen, chars_seen);
      $display("longest text %0d chars; idle bursts both sides and a %0d-cycle output hold",
               longest_text, LONG_HOLD);
      if (failure_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", failure_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sitda_pkg.sv
rtl/sitda_if.sv
rtl/sitda_cell.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sitda_checker.sv
test/sitda_text_checker.sv
test/signed_int_to_decimal_ascii_tb.sv
